>>> hdl/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
// Holds the parser mode enum, result codes, UTF-8 constants and the queue word.
// No dependencies.
`default_nettype none

package jsu_pkg;

  // parser mode
  typedef enum logic [1:0] {
    MODE_WAIT = 2'd0,
    MODE_STR  = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  // result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_CLOSED = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
  localparam logic [2:0] ERR_UNTERM   = 3'd2;
  localparam logic [2:0] ERR_BAD_ESC  = 3'd3;
  localparam logic [2:0] ERR_BAD_HEX  = 3'd4;

  // UTF-8 encoding
  localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;
  localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
  localparam logic [7:0]  UTF8_CONT    = 8'h80;

  localparam int QUEUE_DEPTH = 4;

  // one queued word: a single result, or a code point to expand
  typedef struct packed {
    logic        is_cp;
    logic [1:0]  kind;
    logic [2:0]  err;
    logic [15:0] value;
  } job_t;

endpackage

`default_nettype wire

>>> hdl/json_string_unescaper_unit.sv
// Top level of the JSON string unescaper.
// Instantiates jsu_front, jsu_queue and jsu_back; uses jsu_pkg.
`default_nettype none

// Decodes a quoted JSON string one byte per word. Plain bytes pass through,
// the short escapes give one byte, \uXXXX gives the code point as 1 to 3
// UTF-8 bytes (surrogates are not paired), a closing quote gives a closed
// word and faults give an error word; after a fault every byte up to the
// next quote reports "no opening quote". The output register drains one
// result per cycle while out_ready is high, so a byte producing n results
// occupies the output for n words. The queue of QUEUE_DEPTH words between
// the two absorbs the bursts from \u escapes; input stalls only when that
// queue is full.
module json_string_unescaper_unit #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic [2:0]      error_code,
  output logic            last_of_run
);

  jsu_pkg::job_t push_job, head_job;
  logic          push, pop, q_full, q_empty;

  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (push_job),
    .pop    (pop),
    .head   (head_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head_job),
    .empty       (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_kind    (out_kind),
    .error_code  (error_code),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

>>> hdl/jsu_front.sv
// Front end of the JSON string unescaper: accepts input bytes, tracks the
// parser mode and pushes one word per result-bearing byte. Uses jsu_pkg.
`default_nettype none

module jsu_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_byte,
  input  wire logic         q_full,
  output logic              push,
  output jsu_pkg::job_t     job
);

  jsu_pkg::mode_t mode, mode_next;
  logic [1:0]     hex_count, hex_count_next;
  logic [15:0]    code_point, code_point_next;

  logic        take;
  logic        hex_ok;
  logic [3:0]  hex_digit;
  logic        esc_ok;
  logic [7:0]  esc_byte;
  logic [15:0] cp_shifted;

  assign in_ready   = !q_full;
  assign take       = in_valid && in_ready;
  assign cp_shifted = {code_point[11:0], hex_digit};

  always_comb begin
    hex_ok    = 1'b1;
    hex_digit = 4'd0;
    if (in_byte inside {[8'h30:8'h39]}) begin
      hex_digit = 4'(in_byte - 8'h30);
    end else if (in_byte inside {[8'h61:8'h66]}) begin
      hex_digit = 4'(in_byte - 8'h57);
    end else if (in_byte inside {[8'h41:8'h46]}) begin
      hex_digit = 4'(in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = in_byte;
    case (in_byte)
      8'h22, 8'h5C, 8'h2F: esc_byte = in_byte;
      8'h6E: esc_byte = 8'h0A;
      8'h74: esc_byte = 8'h09;
      8'h72: esc_byte = 8'h0D;
      8'h62: esc_byte = 8'h08;
      8'h66: esc_byte = 8'h0C;
      default: esc_ok = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    mode_next       = mode;
    hex_count_next  = hex_count;
    code_point_next = code_point;
    case (mode)
      jsu_pkg::MODE_WAIT: begin
        if (in_byte == 8'h22) mode_next = jsu_pkg::MODE_STR;
      end
      jsu_pkg::MODE_STR: begin
        if (in_byte == 8'h00 || in_byte == 8'h22) begin
          mode_next = jsu_pkg::MODE_WAIT;
        end else if (in_byte == 8'h5C) begin
          mode_next = jsu_pkg::MODE_ESC;
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (in_byte == 8'h75) begin
          mode_next       = jsu_pkg::MODE_HEX;
          hex_count_next  = 2'd0;
          code_point_next = 16'd0;
        end else if (esc_ok) begin
          mode_next = jsu_pkg::MODE_STR;
        end else begin
          mode_next = jsu_pkg::MODE_WAIT;
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (!hex_ok) begin
          mode_next       = jsu_pkg::MODE_WAIT;
          hex_count_next  = 2'd0;
          code_point_next = 16'd0;
        end else if (hex_count != 2'd3) begin
          hex_count_next  = hex_count + 2'd1;
          code_point_next = cp_shifted;
        end else begin
          mode_next       = jsu_pkg::MODE_STR;
          hex_count_next  = 2'd0;
          code_point_next = 16'd0;
        end
      end
      default: mode_next = jsu_pkg::MODE_WAIT;
    endcase
  end

  // outputs: which word, if any, this byte pushes
  always_comb begin
    push      = 1'b0;
    job.is_cp = 1'b0;
    job.kind  = jsu_pkg::KIND_DATA;
    job.err   = jsu_pkg::ERR_NONE;
    job.value = 16'd0;
    case (mode)
      jsu_pkg::MODE_WAIT: begin
        if (in_byte != 8'h22) begin
          push     = take;
          job.kind = jsu_pkg::KIND_ERROR;
          job.err  = jsu_pkg::ERR_NO_QUOTE;
        end
      end
      jsu_pkg::MODE_STR: begin
        if (in_byte == 8'h00) begin
          push     = take;
          job.kind = jsu_pkg::KIND_ERROR;
          job.err  = jsu_pkg::ERR_UNTERM;
        end else if (in_byte == 8'h22) begin
          push     = take;
          job.kind = jsu_pkg::KIND_CLOSED;
        end else if (in_byte != 8'h5C) begin
          push      = take;
          job.value = {8'd0, in_byte};
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (in_byte != 8'h75) begin
          push = take;
          if (esc_ok) begin
            job.value = {8'd0, esc_byte};
          end else begin
            job.kind = jsu_pkg::KIND_ERROR;
            job.err  = jsu_pkg::ERR_BAD_ESC;
          end
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (!hex_ok) begin
          push     = take;
          job.kind = jsu_pkg::KIND_ERROR;
          job.err  = jsu_pkg::ERR_BAD_HEX;
        end else if (hex_count == 2'd3) begin
          push      = take;
          job.is_cp = 1'b1;
          job.value = cp_shifted;
        end
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= jsu_pkg::MODE_WAIT;
      hex_count  <= 2'd0;
      code_point <= 16'd0;
    end else if (take) begin
      mode       <= mode_next;
      hex_count  <= hex_count_next;
      code_point <= code_point_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/jsu_queue.sv
// Small flop-based FIFO of job words between front and back ends.
// Uses jsu_pkg for the word type.
`default_nettype none

module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire jsu_pkg::job_t wr_job,
  input  wire logic          pop,
  output jsu_pkg::job_t      head,
  output logic               full,
  output logic               empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jsu_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/jsu_back.sv
// Back end of the JSON string unescaper: expands queued words into result
// words (UTF-8 bytes for code points) into a registered output. Uses jsu_pkg.
`default_nettype none

module jsu_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire jsu_pkg::job_t head,
  input  wire logic          empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic [1:0]         out_kind,
  output logic [2:0]         error_code,
  output logic               last_of_run
);

  logic [1:0] idx;
  logic [1:0] n_bytes;
  logic       load;
  logic       last;
  logic [7:0] byte_sel;

  assign load = !empty && (!out_valid || out_ready);
  assign last = (idx == n_bytes - 2'd1);
  assign pop  = load && last;

  always_comb begin
    if (!head.is_cp || head.value < jsu_pkg::CP_ONE_LIMIT) begin
      n_bytes = 2'd1;
    end else if (head.value < jsu_pkg::CP_TWO_LIMIT) begin
      n_bytes = 2'd2;
    end else begin
      n_bytes = 2'd3;
    end
  end

  always_comb begin
    case (idx)
      2'd0: begin
        if (n_bytes == 2'd1) begin
          byte_sel = head.value[7:0];
        end else if (n_bytes == 2'd2) begin
          byte_sel = jsu_pkg::UTF8_LEAD2 | {3'd0, head.value[10:6]};
        end else begin
          byte_sel = jsu_pkg::UTF8_LEAD3 | {4'd0, head.value[15:12]};
        end
      end
      2'd1: begin
        if (n_bytes == 2'd2) begin
          byte_sel = jsu_pkg::UTF8_CONT | {2'd0, head.value[5:0]};
        end else begin
          byte_sel = jsu_pkg::UTF8_CONT | {2'd0, head.value[11:6]};
        end
      end
      default: byte_sel = jsu_pkg::UTF8_CONT | {2'd0, head.value[5:0]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= byte_sel;
      out_kind    <= head.kind;
      error_code  <= head.err;
      last_of_run <= last;
    end
  end

endmodule

`default_nettype wire
